// File: hdl/rpn_stack_calculator_macros.svh
// ----------------------------------------------------------------------------
// RPN stack calculator assertion macros
// Shorthand for clocked concurrent assertions used by the checker.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_MACROS_SVH
`define RPN_STACK_CALCULATOR_MACROS_SVH

// assertion disabled while reset is asserted
`define RSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rsc assertion failed");

// assertion that also holds during reset
`define RSC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rsc assertion failed");

`endif

// File: hdl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared constants and types of the RPN stack calculator.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 64;
  localparam int OCC_W       = 5;

  localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_PUSH  = 3'd0;
  localparam cmd_t CMD_ADD   = 3'd1;
  localparam cmd_t CMD_SUB   = 3'd2;
  localparam cmd_t CMD_MUL   = 3'd3;
  localparam cmd_t CMD_DIV   = 3'd4;
  localparam cmd_t CMD_PRINT = 3'd5;
  localparam cmd_t CMD_CLEAR = 3'd6;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_FEW   = 2'd2;
  localparam status_t ST_EMPTY = 2'd3;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

endpackage

// File: hdl/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish calculator on a 16-entry stack of signed Q32.32 values.
// ----------------------------------------------------------------------------
// One command per transfer in, one result transfer out per command (one per
// entry for print, bottom first, tlast on the top entry; code seven gives
// none). Add, subtract, multiply and divide make two stack reads through the
// single registered read port and then run in the one-bit-per-cycle serial
// arithmetic unit. Print loads the next entry in the cycle after the previous
// transfer. A new command is taken once the previous result has been
// transferred.
module rpn_stack_calculator import rsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // cmd[2:0], operand[66:3], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // status[1:0], result_value[65:2], occupancy[70:66]
  output logic        m_axis_tlast
);

  typedef enum logic [2:0] {S_IDLE, S_RD1, S_RD2, S_ALU, S_PRD} state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [ADDR_W-1:0] idx_q;
  logic [DATA_W-1:0] b_q;
  alu_op_e           op_q;
  logic              ov_q, olast_q;
  status_t           ost_q;
  logic [DATA_W-1:0] oval_q;
  logic [OCC_W-1:0]  oocc_q;

  cmd_t              cmd;
  logic [DATA_W-1:0] operand;
  logic              accept, full, few, plast;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata, alu_res;
  logic              alu_done;
  alu_req_t          alu_req;

  assign cmd     = s_axis_tdata[2:0];
  assign operand = s_axis_tdata[66:3];
  assign s_axis_tready = (state_q == S_IDLE) && !ov_q;
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign full    = (cnt_q == CNT_W'(STACK_DEPTH));
  assign few     = (cnt_q < CNT_W'(2));
  assign cnt_m1  = cnt_q - CNT_W'(1);
  assign cnt_m2  = cnt_q - CNT_W'(2);
  assign plast   = (idx_q == cnt_m1[ADDR_W-1:0]);

  function automatic alu_op_e to_op(input cmd_t c);
    case (c)
      CMD_ADD: to_op = OP_ADD;
      CMD_SUB: to_op = OP_SUB;
      CMD_MUL: to_op = OP_MUL;
      default: to_op = OP_DIV;
    endcase
  endfunction

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = cnt_q[ADDR_W-1:0];
    raddr = cnt_m1[ADDR_W-1:0];
    wdata = operand;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_PUSH: we = !full;
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: re = !few;
            CMD_PRINT: begin
              re    = (cnt_q != '0);
              raddr = '0;
            end
            default: ;
          endcase
        end
      end
      S_RD1: begin
        re    = 1'b1;
        raddr = cnt_m2[ADDR_W-1:0];
      end
      S_ALU: begin
        we    = alu_done;
        waddr = cnt_m2[ADDR_W-1:0];
        wdata = alu_res;
      end
      S_PRD: begin
        re    = !ov_q && !plast;
        raddr = idx_q + ADDR_W'(1);
      end
      default: ;
    endcase
  end

  assign alu_req.start = (state_q == S_RD2);
  assign alu_req.op    = op_q;

  rsc_stack u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  rsc_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (rdata),
    .b_i    (b_q),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      b_q     <= '0;
      op_q    <= OP_ADD;
      ov_q    <= 1'b0;
      olast_q <= 1'b0;
      ost_q   <= ST_OK;
      oval_q  <= '0;
      oocc_q  <= '0;
    end else begin
      if (ov_q && m_axis_tready) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            olast_q <= 1'b1;
            oval_q  <= '0;
            ost_q   <= ST_OK;
            oocc_q  <= OCC_W'(cnt_q);
            op_q    <= to_op(cmd);
            case (cmd)
              CMD_PUSH: begin
                ov_q <= 1'b1;
                if (full) begin
                  ost_q <= ST_FULL;
                end else begin
                  cnt_q  <= cnt_q + CNT_W'(1);
                  oocc_q <= OCC_W'(cnt_q + CNT_W'(1));
                end
              end
              CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                if (few) begin
                  ov_q  <= 1'b1;
                  ost_q <= ST_FEW;
                end else begin
                  state_q <= S_RD1;
                end
              end
              CMD_PRINT: begin
                if (cnt_q == '0) begin
                  ov_q  <= 1'b1;
                  ost_q <= ST_EMPTY;
                end else begin
                  idx_q   <= '0;
                  state_q <= S_PRD;
                end
              end
              CMD_CLEAR: begin
                ov_q   <= 1'b1;
                cnt_q  <= '0;
                oocc_q <= '0;
              end
              default: ;
            endcase
          end
        end
        S_RD1: begin
          b_q     <= rdata;
          state_q <= S_RD2;
        end
        S_RD2: state_q <= S_ALU;
        S_ALU: begin
          if (alu_done) begin
            cnt_q   <= cnt_m1;
            oocc_q  <= OCC_W'(cnt_m1);
            oval_q  <= alu_res;
            ov_q    <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_PRD: begin
          if (!ov_q) begin
            ov_q    <= 1'b1;
            oval_q  <= rdata;
            olast_q <= plast;
            if (plast) begin
              state_q <= S_IDLE;
            end else begin
              idx_q <= idx_q + ADDR_W'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {1'b0, oocc_q, oval_q, ost_q};

endmodule

// File: hdl/rsc_stack.sv
// ----------------------------------------------------------------------------
// rsc_stack
// Operand stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rsc_stack import rsc_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [STACK_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rsc_alu.sv
// ----------------------------------------------------------------------------
// rsc_alu
// Serial Q32.32 unit: bit-serial add/subtract, shift-add multiply and
// restoring divide, one bit per cycle, with saturation at the end.
// ----------------------------------------------------------------------------
module rsc_alu import rsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  alu_req_t          req_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  output logic              done_o,
  output logic [DATA_W-1:0] res_o
);

  typedef enum logic [1:0] {ALU_IDLE, ALU_RUN, ALU_FIN} alu_state_e;

  localparam int FRAC_W = 32;
  localparam int CYC_W  = 7;
  localparam logic [CYC_W-1:0] MULADD_LAST = CYC_W'(DATA_W - 1);
  localparam logic [CYC_W-1:0] DIV_LAST    = CYC_W'(DATA_W + FRAC_W - 1);

  alu_state_e        state_q;
  alu_op_e           op_q;
  logic [CYC_W-1:0]  cnt_q;
  logic [DATA_W-1:0] hi_q, lo_q, y_q, qt_q, res_q;
  logic              carry_q, sa_q, sb_q, ovf_q, zero_q, done_q;

  logic              sbit, cout;
  logic [DATA_W:0]   msum;
  logic [DATA_W-1:0] dt;
  logic              dge;
  logic [DATA_W-1:0] fin_res;

  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
    mag = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

  function automatic logic [DATA_W-1:0] sat(input logic neg, input logic [DATA_W-1:0] m,
                                           input logic o);
    if (neg) begin
      sat = (o || (m > Q_MIN)) ? Q_MIN : (~m + DATA_W'(1));
    end else begin
      sat = (o || m[DATA_W-1]) ? Q_MAX : m;
    end
  endfunction

  always_comb begin
    sbit = lo_q[0] ^ y_q[0] ^ carry_q;
    cout = (lo_q[0] & y_q[0]) | (lo_q[0] & carry_q) | (y_q[0] & carry_q);
    msum = lo_q[0] ? ({1'b0, hi_q} + {1'b0, y_q}) : {1'b0, hi_q};
    dt   = {hi_q[DATA_W-2:0], lo_q[DATA_W-1]};
    dge  = (dt >= y_q);
    case (op_q)
      OP_ADD: fin_res = ((sa_q == sb_q) && (hi_q[DATA_W-1] != sa_q)) ?
                        (sa_q ? Q_MIN : Q_MAX) : hi_q;
      OP_SUB: fin_res = ((sa_q != sb_q) && (hi_q[DATA_W-1] != sa_q)) ?
                        (sa_q ? Q_MIN : Q_MAX) : hi_q;
      OP_MUL: fin_res = sat(sa_q ^ sb_q, {hi_q[FRAC_W-1:0], lo_q[DATA_W-1:FRAC_W]},
                            |hi_q[DATA_W-1:FRAC_W]);
      OP_DIV: begin
        if (zero_q) begin
          fin_res = (lo_q == '0) ? '0 : (sa_q ? Q_MIN : Q_MAX);
        end else begin
          fin_res = sat(sa_q ^ sb_q, qt_q, ovf_q);
        end
      end
      default: fin_res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ALU_IDLE;
      op_q    <= OP_ADD;
      cnt_q   <= '0;
      hi_q    <= '0;
      lo_q    <= '0;
      y_q     <= '0;
      qt_q    <= '0;
      res_q   <= '0;
      carry_q <= 1'b0;
      sa_q    <= 1'b0;
      sb_q    <= 1'b0;
      ovf_q   <= 1'b0;
      zero_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ALU_IDLE: begin
          if (req_i.start) begin
            op_q   <= req_i.op;
            sa_q   <= a_i[DATA_W-1];
            sb_q   <= b_i[DATA_W-1];
            hi_q   <= '0;
            qt_q   <= '0;
            ovf_q  <= 1'b0;
            zero_q <= 1'b0;
            state_q <= ALU_RUN;
            case (req_i.op)
              OP_ADD, OP_SUB: begin
                lo_q    <= a_i;
                y_q     <= (req_i.op == OP_SUB) ? ~b_i : b_i;
                carry_q <= (req_i.op == OP_SUB);
                cnt_q   <= MULADD_LAST;
              end
              OP_MUL: begin
                y_q   <= mag(a_i);
                lo_q  <= mag(b_i);
                cnt_q <= MULADD_LAST;
              end
              default: begin
                y_q    <= mag(b_i);
                lo_q   <= mag(a_i);
                cnt_q  <= DIV_LAST;
                zero_q <= (b_i == '0);
                if (b_i == '0) begin
                  state_q <= ALU_FIN;
                end
              end
            endcase
          end
        end
        ALU_RUN: begin
          case (op_q)
            OP_ADD, OP_SUB: begin
              carry_q <= cout;
              lo_q    <= {1'b0, lo_q[DATA_W-1:1]};
              y_q     <= {1'b0, y_q[DATA_W-1:1]};
              hi_q    <= {sbit, hi_q[DATA_W-1:1]};
            end
            OP_MUL: begin
              hi_q <= msum[DATA_W:1];
              lo_q <= {msum[0], lo_q[DATA_W-1:1]};
            end
            default: begin
              hi_q  <= dge ? (dt - y_q) : dt;
              lo_q  <= {lo_q[DATA_W-2:0], 1'b0};
              qt_q  <= {qt_q[DATA_W-2:0], dge};
              ovf_q <= ovf_q | qt_q[DATA_W-1];
            end
          endcase
          if (cnt_q == '0) begin
            state_q <= ALU_FIN;
          end else begin
            cnt_q <= cnt_q - CYC_W'(1);
          end
        end
        ALU_FIN: begin
          res_q   <= fin_res;
          done_q  <= 1'b1;
          state_q <= ALU_IDLE;
        end
        default: state_q <= ALU_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: hdl/rsc_checker.sv
// ----------------------------------------------------------------------------
// rsc_checker
// Port-level checks of the RPN stack calculator, bound to the top level.
// ----------------------------------------------------------------------------
`include "rpn_stack_calculator_macros.svh"

module rsc_checker import rsc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  status_t          st;
  logic [OCC_W-1:0] occ;

  assign st  = m_axis_tdata[1:0];
  assign occ = m_axis_tdata[70:66];

  `RSC_ASSERT(out_hold_a, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `RSC_ASSERT(empty_a, m_axis_tvalid && st == ST_EMPTY |-> m_axis_tlast && occ == '0)
  `RSC_ASSERT(full_a, m_axis_tvalid && st == ST_FULL |->
    occ == OCC_W'(STACK_DEPTH) && m_axis_tdata[65:2] == '0)
  `RSC_ASSERT(few_a, m_axis_tvalid && st == ST_FEW |-> m_axis_tlast && occ < OCC_W'(2))
  `RSC_ASSERT_ALWAYS(occ_a, !m_axis_tvalid || occ <= OCC_W'(STACK_DEPTH))

endmodule

bind rpn_stack_calculator rsc_checker u_rsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
